/* hw/rtl/wrq_pkg.sv */
`default_nettype none
package wrq_pkg;

   localparam int HISTORY_DEPTH = 5;

   // physical valid ranges, bounds inclusive
   localparam logic signed [11:0] TEMP_LO  = -12'sd400;
   localparam logic signed [11:0] TEMP_HI  = 12'sd850;
   localparam logic signed [11:0] HUMID_LO = 12'sd0;
   localparam logic signed [11:0] HUMID_HI = 12'sd1000;
   localparam logic [13:0] PRESS_LO = 14'd3000;
   localparam logic [13:0] PRESS_HI = 14'd11000;
   localparam logic signed [12:0] UV_LO = 13'sd0;
   localparam logic signed [12:0] UV_HI = 13'sd2000;
   localparam logic [20:0] LIGHT_HI = 21'd1000000;

   localparam logic signed [10:0] MUGGY_TEMP  = 11'sd250;
   localparam logic [9:0]         MUGGY_HUMID = 10'd500;

   // last good sample after reset
   localparam logic signed [10:0] GOOD_TEMP_RST  = 11'sd200;
   localparam logic [9:0]         GOOD_HUMID_RST = 10'd500;
   localparam logic [13:0]        GOOD_PRESS_RST = 14'd10130;
   localparam logic [10:0]        GOOD_UV_RST    = 11'd0;
   localparam logic [19:0]        GOOD_LIGHT_RST = 20'd1000;

   // limit register resets
   localparam logic signed [10:0] FAST_FALL_RST = -11'sd20;
   localparam logic signed [10:0] SLOW_FALL_RST = -11'sd7;
   localparam logic [9:0]         SLOW_RISE_RST = 10'd7;
   localparam logic [10:0]        UV_DANGER_RST = 11'd800;
   localparam logic [10:0]        UV_STRONG_RST = 11'd600;
   localparam logic signed [10:0] HOT_RST       = 11'sd270;
   localparam logic signed [10:0] COLD_RST      = 11'sd150;
   localparam logic [19:0]        DARK_RST      = 20'd20;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FAST_FALL = 3'd0,
      CSR_SLOW_FALL = 3'd1,
      CSR_SLOW_RISE = 3'd2,
      CSR_UV_DANGER = 3'd3,
      CSR_UV_STRONG = 3'd4,
      CSR_HOT       = 3'd5,
      CSR_COLD      = 3'd6,
      CSR_DARK      = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ADV_RAIN        = 4'd0,
      ADV_SHOWERS     = 4'd1,
      ADV_UV_DANGER   = 4'd2,
      ADV_UV_STRONG   = 4'd3,
      ADV_HOT_HUMID   = 4'd4,
      ADV_HOT         = 4'd5,
      ADV_COLD        = 4'd6,
      ADV_DARK        = 4'd7,
      ADV_CLEARING    = 4'd8,
      ADV_COMFORTABLE = 4'd9
   } advice_type;

   typedef enum logic [2:0] {
      ICON_DROPLET   = 3'd0,
      ICON_CLEAR_SKY = 3'd1,
      ICON_OVERCAST  = 3'd2,
      ICON_LAMP      = 3'd3,
      ICON_SNOW      = 3'd4
   } icon_type;

   typedef enum logic [1:0] {
      TONE_BAD  = 2'd0,
      TONE_WARN = 2'd1,
      TONE_COLD = 2'd2,
      TONE_GOOD = 2'd3
   } tone_type;

   typedef struct packed {
      logic signed [11:0] temp;
      logic signed [11:0] humid;
      logic [13:0]        press;
      logic signed [12:0] uv;
      logic [20:0]        light;
      logic [4:0]         fail_mask;
   } raw_type;

   typedef struct packed {
      logic signed [10:0] temp;
      logic [9:0]         humid;
      logic [13:0]        press;
      logic [10:0]        uv;
      logic [19:0]        light;
   } sample_type;

   typedef struct packed {
      logic signed [10:0] fast_fall;
      logic signed [10:0] slow_fall;
      logic [9:0]         slow_rise;
      logic [10:0]        uv_danger;
      logic [10:0]        uv_strong;
      logic signed [10:0] hot;
      logic signed [10:0] cold;
      logic [19:0]        dark;
   } limits_type;

   typedef struct packed {
      advice_type advice;
      icon_type   icon;
      tone_type   tone;
   } verdict_type;

endpackage
`default_nettype wire

/* hw/rtl/weather_reading_qualifier_core.sv */
`default_nettype none
// channel    ports          fields (lowest bit first)
// request    req_t*         tdata: temp_in, humid_in, press_in, uv_in, light_in
//                           tuser: fail_mask
// response   rsp_t*         tdata: temp_out, humid_out, press_out, uv_out, light_out,
//                                  trend, advice, icon, tone; tuser: stale
// csr        csr_*          write only, index = limit register number
//
// one request per cycle sustained while the response is not stalled; an accepted request
// is held in the input register until the response register can take it
// input register, then qualify / ring / advice logic into the response register
// reset is synchronous, loads the default sample and limits and empties the ring
// a stalled response holds; the input register still takes a request when the
// response register drains in the same cycle
module weather_reading_qualifier_core #(
   parameter int HISTORY_DEPTH = wrq_pkg::HISTORY_DEPTH
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [71:0] req_tdata,   // temp_in, humid_in, press_in, uv_in, light_in
   input  wire  [4:0]  req_tuser,   // fail_mask
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [95:0] rsp_tdata,   // temp_out, humid_out, press_out, uv_out, light_out,
                                    // trend, advice, icon, tone
   output logic        rsp_tuser,   // stale
   input  wire         csr_we,
   input  wire  [wrq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire  [wrq_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   wrq_pkg::raw_type     in_ff;
   logic                 in_valid_ff;
   logic                 advance;

   wrq_pkg::limits_type  lim_ff;

   wrq_pkg::sample_type  chosen;
   logic                 stale;
   logic signed [14:0]   trend;
   wrq_pkg::verdict_type verdict;

   wrq_pkg::sample_type  out_smp_ff;
   logic                 out_stale_ff;
   logic [13:0]          out_trend_ff;
   wrq_pkg::verdict_type out_verdict_ff;
   logic                 out_valid_ff;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ff.temp      <= req_tdata[11:0];
         in_ff.humid     <= req_tdata[23:12];
         in_ff.press     <= req_tdata[37:24];
         in_ff.uv        <= req_tdata[50:38];
         in_ff.light     <= req_tdata[71:51];
         in_ff.fail_mask <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff.fast_fall <= wrq_pkg::FAST_FALL_RST;
         lim_ff.slow_fall <= wrq_pkg::SLOW_FALL_RST;
         lim_ff.slow_rise <= wrq_pkg::SLOW_RISE_RST;
         lim_ff.uv_danger <= wrq_pkg::UV_DANGER_RST;
         lim_ff.uv_strong <= wrq_pkg::UV_STRONG_RST;
         lim_ff.hot       <= wrq_pkg::HOT_RST;
         lim_ff.cold      <= wrq_pkg::COLD_RST;
         lim_ff.dark      <= wrq_pkg::DARK_RST;
      end else if (csr_we) begin
         unique case (wrq_pkg::csr_index_type'(csr_index))
            wrq_pkg::CSR_FAST_FALL: lim_ff.fast_fall <= csr_wdata[10:0];
            wrq_pkg::CSR_SLOW_FALL: lim_ff.slow_fall <= csr_wdata[10:0];
            wrq_pkg::CSR_SLOW_RISE: lim_ff.slow_rise <= csr_wdata[9:0];
            wrq_pkg::CSR_UV_DANGER: lim_ff.uv_danger <= csr_wdata[10:0];
            wrq_pkg::CSR_UV_STRONG: lim_ff.uv_strong <= csr_wdata[10:0];
            wrq_pkg::CSR_HOT:       lim_ff.hot       <= csr_wdata[10:0];
            wrq_pkg::CSR_COLD:      lim_ff.cold      <= csr_wdata[10:0];
            wrq_pkg::CSR_DARK:      lim_ff.dark      <= csr_wdata[19:0];
            default:                lim_ff           <= lim_ff;
         endcase
      end
   end

   wrq_sample u_sample (
      .clock  (clock),
      .reset  (reset),
      .load   (advance),
      .raw    (in_ff),
      .chosen (chosen),
      .stale  (stale)
   );

   wrq_trend #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_trend (
      .clock (clock),
      .reset (reset),
      .load  (advance),
      .press (chosen.press),
      .trend (trend)
   );

   wrq_advice u_advice (
      .smp     (chosen),
      .trend   (trend),
      .lim     (lim_ff),
      .verdict (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_smp_ff     <= chosen;
         out_stale_ff   <= stale;
         out_trend_ff   <= trend[13:0];
         out_verdict_ff <= verdict;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_stale_ff;
   assign rsp_tdata  = {7'd0,
                        out_verdict_ff.tone,
                        out_verdict_ff.icon,
                        out_verdict_ff.advice,
                        out_trend_ff,
                        out_smp_ff.light,
                        out_smp_ff.uv,
                        out_smp_ff.press,
                        out_smp_ff.humid,
                        out_smp_ff.temp};

endmodule
`default_nettype wire

/* hw/rtl/wrq_sample.sv */
`default_nettype none
module wrq_sample (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  load,
   input  wrq_pkg::raw_type     raw,
   output wrq_pkg::sample_type  chosen,
   output logic                 stale
);

   wrq_pkg::sample_type good_ff;
   wrq_pkg::sample_type good_in;
   logic                ok;

   always_comb begin
      ok = (raw.fail_mask == 5'd0)
         && ($signed(raw.temp) >= wrq_pkg::TEMP_LO) && ($signed(raw.temp) <= wrq_pkg::TEMP_HI)
         && ($signed(raw.humid) >= wrq_pkg::HUMID_LO)
         && ($signed(raw.humid) <= wrq_pkg::HUMID_HI)
         && (raw.press >= wrq_pkg::PRESS_LO) && (raw.press <= wrq_pkg::PRESS_HI)
         && ($signed(raw.uv) >= wrq_pkg::UV_LO) && ($signed(raw.uv) <= wrq_pkg::UV_HI)
         && (raw.light <= wrq_pkg::LIGHT_HI);
      good_in.temp  = raw.temp[10:0];
      good_in.humid = raw.humid[9:0];
      good_in.press = raw.press;
      good_in.uv    = raw.uv[10:0];
      good_in.light = raw.light[19:0];
      chosen        = ok ? good_in : good_ff;
      stale         = !ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         good_ff.temp  <= wrq_pkg::GOOD_TEMP_RST;
         good_ff.humid <= wrq_pkg::GOOD_HUMID_RST;
         good_ff.press <= wrq_pkg::GOOD_PRESS_RST;
         good_ff.uv    <= wrq_pkg::GOOD_UV_RST;
         good_ff.light <= wrq_pkg::GOOD_LIGHT_RST;
      end else if (load && ok) begin
         good_ff <= good_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/wrq_trend.sv */
`default_nettype none
module wrq_trend #(
   parameter int HISTORY_DEPTH = wrq_pkg::HISTORY_DEPTH
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                load,
   input  wire [13:0]         press,
   output logic signed [14:0] trend
);

   localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

   logic [13:0]      ring_ff [HISTORY_DEPTH];
   logic [PTR_W-1:0] ptr_ff;
   logic [PTR_W-1:0] ptr_in;
   logic             full_ff;
   logic             full_in;
   logic             wrap;

   always_comb begin
      wrap    = (ptr_ff == PTR_LAST);
      ptr_in  = wrap ? '0 : ptr_ff + 1'b1;
      full_in = full_ff || wrap;
      // oldest entry sits at the next write slot
      if (full_in) begin
         trend = $signed({1'b0, press}) - $signed({1'b0, ring_ff[ptr_in]});
      end else begin
         trend = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         full_ff <= 1'b0;
      end else if (load) begin
         ptr_ff  <= ptr_in;
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ring_ff[ptr_ff] <= press;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/wrq_advice.sv */
`default_nettype none
module wrq_advice (
   input  wrq_pkg::sample_type   smp,
   input  wire signed [14:0]     trend,
   input  wrq_pkg::limits_type   lim,
   output wrq_pkg::verdict_type  verdict
);

   logic signed [14:0] fast_fall_x;
   logic signed [14:0] slow_fall_x;
   logic signed [14:0] slow_rise_x;

   always_comb begin
      fast_fall_x = 15'($signed(lim.fast_fall));
      slow_fall_x = 15'($signed(lim.slow_fall));
      slow_rise_x = $signed({5'd0, lim.slow_rise});
      priority if (trend <= fast_fall_x) begin
         verdict = '{wrq_pkg::ADV_RAIN, wrq_pkg::ICON_DROPLET, wrq_pkg::TONE_BAD};
      end else if (trend <= slow_fall_x) begin
         verdict = '{wrq_pkg::ADV_SHOWERS, wrq_pkg::ICON_DROPLET, wrq_pkg::TONE_WARN};
      end else if (smp.uv >= lim.uv_danger) begin
         verdict = '{wrq_pkg::ADV_UV_DANGER, wrq_pkg::ICON_CLEAR_SKY, wrq_pkg::TONE_BAD};
      end else if (smp.uv >= lim.uv_strong) begin
         verdict = '{wrq_pkg::ADV_UV_STRONG, wrq_pkg::ICON_CLEAR_SKY, wrq_pkg::TONE_WARN};
      end else if (($signed(smp.temp) > wrq_pkg::MUGGY_TEMP)
                   && (smp.humid > wrq_pkg::MUGGY_HUMID)) begin
         verdict = '{wrq_pkg::ADV_HOT_HUMID, wrq_pkg::ICON_CLEAR_SKY, wrq_pkg::TONE_WARN};
      end else if ($signed(smp.temp) > $signed(lim.hot)) begin
         verdict = '{wrq_pkg::ADV_HOT, wrq_pkg::ICON_CLEAR_SKY, wrq_pkg::TONE_WARN};
      end else if ($signed(smp.temp) < $signed(lim.cold)) begin
         verdict = '{wrq_pkg::ADV_COLD, wrq_pkg::ICON_SNOW, wrq_pkg::TONE_COLD};
      end else if (smp.light < lim.dark) begin
         verdict = '{wrq_pkg::ADV_DARK, wrq_pkg::ICON_LAMP, wrq_pkg::TONE_WARN};
      end else if (trend >= slow_rise_x) begin
         verdict = '{wrq_pkg::ADV_CLEARING, wrq_pkg::ICON_CLEAR_SKY, wrq_pkg::TONE_GOOD};
      end else begin
         verdict = '{wrq_pkg::ADV_COMFORTABLE, wrq_pkg::ICON_OVERCAST, wrq_pkg::TONE_GOOD};
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/wrq_checker.sv */
`default_nettype none
module wrq_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [95:0] rsp_tdata,
   input wire        rsp_tuser
);

   logic [3:0] adv;
   logic [2:0] icn;
   logic [1:0] tn;

   assign adv = rsp_tdata[83:80];
   assign icn = rsp_tdata[86:84];
   assign tn  = rsp_tdata[88:87];

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // rain advice always carries rain icon and bad tone
   a_rain_map: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (adv == wrq_pkg::ADV_RAIN) |->
         (icn == wrq_pkg::ICON_DROPLET) && (tn == wrq_pkg::TONE_BAD))
      else $error("rain advice with wrong icon or tone");

   // cold advice always carries snowflake and cold tone
   a_cold_map: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (adv == wrq_pkg::ADV_COLD) |->
         (icn == wrq_pkg::ICON_SNOW) && (tn == wrq_pkg::TONE_COLD))
      else $error("cold advice with wrong icon or tone");

   // an accepted request, when no response is pending, becomes a valid response after the input and response registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> ##1 rsp_tvalid)
      else $error("response missing after request");

endmodule

bind weather_reading_qualifier_core wrq_checker u_wrq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

/* bench/weather_reading_qualifier_core_tb.sv */
`timescale 1ns / 100ps
module weather_reading_qualifier_core_tb;

   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      wrq_pkg::sample_type  sample;
      logic                 stale;
      logic signed [13:0]   trend;
      wrq_pkg::verdict_type verdict;
   } forecast_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [71:0] req_tdata = '0;
   logic [4:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_we = 1'b0;
   logic [wrq_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [wrq_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   weather_reading_qualifier_core dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // limits and last good sample as the block should hold them
   int lim_fast_fall = wrq_pkg::FAST_FALL_RST;
   int lim_slow_fall = wrq_pkg::SLOW_FALL_RST;
   int lim_slow_rise = wrq_pkg::SLOW_RISE_RST;
   int lim_uv_danger = wrq_pkg::UV_DANGER_RST;
   int lim_uv_strong = wrq_pkg::UV_STRONG_RST;
   int lim_hot = wrq_pkg::HOT_RST;
   int lim_cold = wrq_pkg::COLD_RST;
   int lim_dark = wrq_pkg::DARK_RST;
   int good_temp = wrq_pkg::GOOD_TEMP_RST;
   int good_humid = wrq_pkg::GOOD_HUMID_RST;
   int good_press = wrq_pkg::GOOD_PRESS_RST;
   int good_uv = wrq_pkg::GOOD_UV_RST;
   int good_light = wrq_pkg::GOOD_LIGHT_RST;
   int press_hist[wrq_pkg::HISTORY_DEPTH];
   int hist_ptr = 0;
   bit hist_full = 1'b0;

   forecast_type forecast_q[$];
   forecast_type due;
   int mismatch_count = 0;
   int cycle_count = 0;
   int hold_off_left = 0;
   int stall_left = 0;
   bit steady_flow = 1'b0;
   int drift_press = 10130;

   function automatic forecast_type qualify_reading(wrq_pkg::raw_type r);
      int t, h, p, u, l, trend;
      bit ok;
      forecast_type f;
      t = r.temp;
      h = r.humid;
      p = r.press;
      u = r.uv;
      l = r.light;
      ok = r.fail_mask == 0
         && t >= int'(wrq_pkg::TEMP_LO) && t <= int'(wrq_pkg::TEMP_HI)
         && h >= int'(wrq_pkg::HUMID_LO) && h <= int'(wrq_pkg::HUMID_HI)
         && p >= int'(wrq_pkg::PRESS_LO) && p <= int'(wrq_pkg::PRESS_HI)
         && u >= int'(wrq_pkg::UV_LO) && u <= int'(wrq_pkg::UV_HI)
         && l <= int'(wrq_pkg::LIGHT_HI);
      if (ok) begin
         good_temp = t;
         good_humid = h;
         good_press = p;
         good_uv = u;
         good_light = l;
      end
      press_hist[hist_ptr] = good_press;
      hist_ptr++;
      if (hist_ptr == wrq_pkg::HISTORY_DEPTH) begin
         hist_ptr = 0;
         hist_full = 1'b1;
      end
      trend = hist_full ? good_press - press_hist[hist_ptr] : 0;

      if (trend <= lim_fast_fall)
         f.verdict = '{wrq_pkg::ADV_RAIN, wrq_pkg::ICON_DROPLET, wrq_pkg::TONE_BAD};
      else if (trend <= lim_slow_fall)
         f.verdict = '{wrq_pkg::ADV_SHOWERS, wrq_pkg::ICON_DROPLET, wrq_pkg::TONE_WARN};
      else if (good_uv >= lim_uv_danger)
         f.verdict = '{wrq_pkg::ADV_UV_DANGER, wrq_pkg::ICON_CLEAR_SKY, wrq_pkg::TONE_BAD};
      else if (good_uv >= lim_uv_strong)
         f.verdict = '{wrq_pkg::ADV_UV_STRONG, wrq_pkg::ICON_CLEAR_SKY, wrq_pkg::TONE_WARN};
      else if (good_temp > int'(wrq_pkg::MUGGY_TEMP)
               && good_humid > int'(wrq_pkg::MUGGY_HUMID))
         f.verdict = '{wrq_pkg::ADV_HOT_HUMID, wrq_pkg::ICON_CLEAR_SKY, wrq_pkg::TONE_WARN};
      else if (good_temp > lim_hot)
         f.verdict = '{wrq_pkg::ADV_HOT, wrq_pkg::ICON_CLEAR_SKY, wrq_pkg::TONE_WARN};
      else if (good_temp < lim_cold)
         f.verdict = '{wrq_pkg::ADV_COLD, wrq_pkg::ICON_SNOW, wrq_pkg::TONE_COLD};
      else if (good_light < lim_dark)
         f.verdict = '{wrq_pkg::ADV_DARK, wrq_pkg::ICON_LAMP, wrq_pkg::TONE_WARN};
      else if (trend >= lim_slow_rise)
         f.verdict = '{wrq_pkg::ADV_CLEARING, wrq_pkg::ICON_CLEAR_SKY, wrq_pkg::TONE_GOOD};
      else
         f.verdict = '{wrq_pkg::ADV_COMFORTABLE, wrq_pkg::ICON_OVERCAST, wrq_pkg::TONE_GOOD};

      f.sample.temp = good_temp[10:0];
      f.sample.humid = good_humid[9:0];
      f.sample.press = good_press[13:0];
      f.sample.uv = good_uv[10:0];
      f.sample.light = good_light[19:0];
      f.stale = !ok;
      f.trend = trend[13:0];
      return f;
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && csr_we) begin
         case (csr_index)
            wrq_pkg::CSR_FAST_FALL: lim_fast_fall = int'($signed(csr_wdata[10:0]));
            wrq_pkg::CSR_SLOW_FALL: lim_slow_fall = int'($signed(csr_wdata[10:0]));
            wrq_pkg::CSR_SLOW_RISE: lim_slow_rise = int'(csr_wdata[9:0]);
            wrq_pkg::CSR_UV_DANGER: lim_uv_danger = int'(csr_wdata[10:0]);
            wrq_pkg::CSR_UV_STRONG: lim_uv_strong = int'(csr_wdata[10:0]);
            wrq_pkg::CSR_HOT: lim_hot = int'($signed(csr_wdata[10:0]));
            wrq_pkg::CSR_COLD: lim_cold = int'($signed(csr_wdata[10:0]));
            wrq_pkg::CSR_DARK: lim_dark = int'(csr_wdata[19:0]);
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin
      wrq_pkg::raw_type r;
      if (!reset && req_tvalid && req_tready) begin
         r.temp = req_tdata[11:0];
         r.humid = req_tdata[23:12];
         r.press = req_tdata[37:24];
         r.uv = req_tdata[50:38];
         r.light = req_tdata[71:51];
         r.fail_mask = req_tuser;
         forecast_q.push_back(qualify_reading(r));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (forecast_q.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            due = forecast_q.pop_front();
            if (rsp_tdata[10:0] !== due.sample.temp) begin
               $error("temp_out: expected %0d, got %0d", due.sample.temp,
                      $signed(rsp_tdata[10:0]));
               mismatch_count++;
            end
            if (rsp_tdata[20:11] !== due.sample.humid) begin
               $error("humid_out: expected %0d, got %0d", due.sample.humid, rsp_tdata[20:11]);
               mismatch_count++;
            end
            if (rsp_tdata[34:21] !== due.sample.press) begin
               $error("press_out: expected %0d, got %0d", due.sample.press, rsp_tdata[34:21]);
               mismatch_count++;
            end
            if (rsp_tdata[45:35] !== due.sample.uv) begin
               $error("uv_out: expected %0d, got %0d", due.sample.uv, rsp_tdata[45:35]);
               mismatch_count++;
            end
            if (rsp_tdata[65:46] !== due.sample.light) begin
               $error("light_out: expected %0d, got %0d", due.sample.light, rsp_tdata[65:46]);
               mismatch_count++;
            end
            if (rsp_tuser !== due.stale) begin
               $error("stale: expected %0d, got %0d", due.stale, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tdata[79:66] !== due.trend) begin
               $error("trend: expected %0d, got %0d", due.trend, $signed(rsp_tdata[79:66]));
               mismatch_count++;
            end
            if (rsp_tdata[83:80] !== due.verdict.advice) begin
               $error("advice: expected %0d, got %0d", due.verdict.advice, rsp_tdata[83:80]);
               mismatch_count++;
            end
            if (rsp_tdata[86:84] !== due.verdict.icon) begin
               $error("icon: expected %0d, got %0d", due.verdict.icon, rsp_tdata[86:84]);
               mismatch_count++;
            end
            if (rsp_tdata[88:87] !== due.verdict.tone) begin
               $error("tone: expected %0d, got %0d", due.verdict.tone, rsp_tdata[88:87]);
               mismatch_count++;
            end
         end
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_flow || roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // response side readiness
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_tready <= 1'b0;
            hold_off_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   task automatic send_reading(wrq_pkg::raw_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {r.light, r.uv, r.press, r.humid, r.temp};
      req_tuser <= r.fail_mask;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (forecast_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_limit(wrq_pkg::csr_index_type idx, int value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[19:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic program_limits(int fast_fall, int slow_fall, int slow_rise, int uv_danger,
                                 int uv_strong, int hot, int cold, int dark);
      write_limit(wrq_pkg::CSR_FAST_FALL, fast_fall);
      write_limit(wrq_pkg::CSR_SLOW_FALL, slow_fall);
      write_limit(wrq_pkg::CSR_SLOW_RISE, slow_rise);
      write_limit(wrq_pkg::CSR_UV_DANGER, uv_danger);
      write_limit(wrq_pkg::CSR_UV_STRONG, uv_strong);
      write_limit(wrq_pkg::CSR_HOT, hot);
      write_limit(wrq_pkg::CSR_COLD, cold);
      write_limit(wrq_pkg::CSR_DARK, dark);
   endtask

   function automatic wrq_pkg::raw_type make_raw(int t, int h, int p, int u, int l, int mask);
      wrq_pkg::raw_type r;
      r.temp = 12'(t);
      r.humid = 12'(h);
      r.press = 14'(p);
      r.uv = 13'(u);
      r.light = 21'(l);
      r.fail_mask = 5'(mask);
      return r;
   endfunction

   // slowly drifting pressure with random content, plus some noise
   function automatic wrq_pkg::raw_type weather_drift_reading();
      wrq_pkg::raw_type r;
      logic [95:0] noise;
      int roll, step;
      roll = $urandom_range(0, 99);
      if (roll >= 96) begin
         noise = {$urandom(), $urandom(), $urandom()};
         r = noise[76:0];
         return r;
      end
      if ($urandom_range(0, 49) == 0) drift_press = $urandom_range(3000, 11000);
      step = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 80)) - 40
                                         : int'($urandom_range(0, 12)) - 6;
      drift_press += step;
      if (drift_press < 3000) drift_press = 3000;
      if (drift_press > 11000) drift_press = 11000;
      r.temp = 12'(int'($urandom_range(0, 1250)) - 400);
      r.humid = 12'($urandom_range(0, 1000));
      r.press = 14'(drift_press);
      r.uv = 13'($urandom_range(0, 1) ? $urandom_range(0, 2000) : $urandom_range(0, 500));
      r.light = 21'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 100)
                                                 : $urandom_range(0, 1000000));
      r.fail_mask = 5'd0;
      if (roll >= 80 && roll < 88) begin
         r.fail_mask = 5'($urandom_range(1, 31));
      end else if (roll >= 88) begin
         case ($urandom_range(0, 4))
            0: r.temp = 12'($urandom_range(0, 1) ? -$urandom_range(401, 2048)
                                                 : $urandom_range(851, 2047));
            1: r.humid = 12'($urandom_range(0, 1) ? -$urandom_range(1, 2048)
                                                  : $urandom_range(1001, 2047));
            2: r.press = 14'($urandom_range(0, 1) ? $urandom_range(0, 2999)
                                                  : $urandom_range(11001, 16383));
            3: r.uv = 13'($urandom_range(0, 1) ? -$urandom_range(1, 4096)
                                               : $urandom_range(2001, 4095));
            default: r.light = 21'($urandom_range(1000001, 2097151));
         endcase
      end
      return r;
   endfunction

   // trend is still compared while the ring fills
   task automatic test_failed_reads_on_empty_ring();
      write_limit(wrq_pkg::CSR_FAST_FALL, 0);
      send_reading(make_raw(300, 700, 10000, 900, 5000, 5'b00001));
      send_reading(make_raw(300, 700, 10000, 900, 5000, 5'b00010));
      wait_drained();
      write_limit(wrq_pkg::CSR_FAST_FALL, wrq_pkg::FAST_FALL_RST);
      write_limit(wrq_pkg::CSR_SLOW_RISE, 0);
      send_reading(make_raw(300, 700, 10000, 900, 5000, 5'b00100));
      send_reading(make_raw(300, 700, 10000, 900, 5000, 5'b01000));
      wait_drained();
      write_limit(wrq_pkg::CSR_SLOW_RISE, wrq_pkg::SLOW_RISE_RST);
      send_reading(make_raw(300, 700, 10000, 900, 5000, 5'b10000));
      send_reading(make_raw(300, 700, 10000, 900, 5000, 5'b11111));
      wait_drained();
   endtask

   task automatic test_advice_chain();
      send_reading(make_raw(200, 400, 10130, 900, 500, 0));
      send_reading(make_raw(200, 400, 10130, 700, 500, 0));
      send_reading(make_raw(260, 600, 10130, 100, 500, 0));
      send_reading(make_raw(300, 400, 10130, 100, 500, 0));
      send_reading(make_raw(100, 400, 10130, 100, 500, 0));
      send_reading(make_raw(200, 400, 10130, 100, 10, 0));
      send_reading(make_raw(200, 400, 10130, 100, 500, 0));
      send_reading(make_raw(200, 400, 10140, 100, 500, 0));
      send_reading(make_raw(200, 400, 10120, 100, 500, 0));
      send_reading(make_raw(200, 400, 10090, 100, 500, 0));
      wait_drained();
   endtask

   task automatic test_range_edges();
      send_reading(make_raw(-400, 0, 3000, 0, 0, 0));
      send_reading(make_raw(850, 1000, 11000, 2000, 1000000, 0));
      send_reading(make_raw(-401, 500, 10000, 100, 500, 0));
      send_reading(make_raw(851, 500, 10000, 100, 500, 0));
      send_reading(make_raw(200, -1, 10000, 100, 500, 0));
      send_reading(make_raw(200, 1001, 10000, 100, 500, 0));
      send_reading(make_raw(200, 500, 2999, 100, 500, 0));
      send_reading(make_raw(200, 500, 11001, 100, 500, 0));
      send_reading(make_raw(200, 500, 10000, -1, 500, 0));
      send_reading(make_raw(200, 500, 10000, 2001, 500, 0));
      send_reading(make_raw(200, 500, 10000, 100, 1000001, 0));
      send_reading(make_raw(2047, 2047, 16383, 4095, 2097151, 0));
      send_reading(make_raw(-2048, -2048, 0, -4096, 0, 0));
      wait_drained();
   endtask

   task automatic test_random_phases();
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: program_limits(wrq_pkg::FAST_FALL_RST, wrq_pkg::SLOW_FALL_RST,
                              wrq_pkg::SLOW_RISE_RST, wrq_pkg::UV_DANGER_RST,
                              wrq_pkg::UV_STRONG_RST, wrq_pkg::HOT_RST, wrq_pkg::COLD_RST,
                              wrq_pkg::DARK_RST);
            1: program_limits(-1000, -1000, 0, 0, 0, -400, -400, 0);
            2: program_limits(0, 0, 1000, 2000, 2000, 850, 850, 1000000);
            3: program_limits(-1024, 1023, 1023, 2047, 2047, 1023, -1024, 1048575);
            7: program_limits($urandom(), $urandom(), $urandom(), $urandom(),
                              $urandom(), $urandom(), $urandom(), $urandom());
            default: program_limits(-int'($urandom_range(0, 80)), -int'($urandom_range(0, 40)),
                                    $urandom_range(0, 40), $urandom_range(0, 2000),
                                    $urandom_range(0, 2000), int'($urandom_range(0, 1250)) - 400,
                                    int'($urandom_range(0, 1250)) - 400,
                                    $urandom_range(0, 1) ? $urandom_range(0, 200)
                                                         : $urandom_range(0, 1000000));
         endcase
         steady_flow = (phase == 3);
         repeat (110) send_reading(weather_drift_reading());
         wait_drained();
      end
      steady_flow = 1'b0;
   endtask

   task automatic test_backpressure();
      steady_flow = 1'b1;
      hold_off_left = 300;
      repeat (40) send_reading(weather_drift_reading());
      steady_flow = 1'b0;
      wait_drained();
      repeat (20) send_reading(weather_drift_reading());
      wait_drained();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_failed_reads_on_empty_ring();
      test_advice_chain();
      test_range_edges();
      test_random_phases();
      test_backpressure();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && forecast_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
